@@ hdl/hpdc_pkg.sv @@
// shared constants, codes and state types for the positivity derivative clamp
// used by the bound unit and the top level; depends on nothing
`default_nettype none

package hpdc_pkg;

  // defaults for the top-level parameters
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // mu is unsigned q0.16, 3*mu needs two more bits
  localparam int MU_W = 16;
  localparam int A_W  = MU_W + 2;

  // register port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // register index, taken from paddr[APB_AW-1]
  localparam logic REG_MU_FACTOR = 1'b0;

  // status codes of a result word
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_SHORT_RUN = 1'b1;

  // top-level sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_BOUND,
    ST_EMIT
  } top_state_e;

  // which result and which bound is being worked on
  typedef enum logic [1:0] {
    PH_A_UP,
    PH_A_LO,
    PH_B_UP,
    PH_SINGLE
  } phase_e;

  // bound unit sequencer
  typedef enum logic [2:0] {
    BS_IDLE,
    BS_MUL,
    BS_CHK,
    BS_DIV,
    BS_SAT
  } bnd_state_e;

endpackage

`default_nettype wire

@@ hdl/hpdc_if.sv @@
// valid/ready channel interfaces for point words and result words
// depends on nothing; widths follow the DATA_WIDTH parameter
`default_nettype none

interface hpdc_in_if #(
  parameter int DATA_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] point_value;
  logic [DATA_WIDTH-1:0] point_slope;
  logic [DATA_WIDTH-1:0] knot;
  logic                  final_point;

  modport source (
    output valid, point_value, point_slope, knot, final_point,
    input  ready
  );
  modport sink (
    input  valid, point_value, point_slope, knot, final_point,
    output ready
  );
endinterface

interface hpdc_out_if #(
  parameter int DATA_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] adjusted_slope;
  logic                  run_end;
  logic                  status;

  modport source (
    output valid, adjusted_slope, run_end, status,
    input  ready
  );
  modport sink (
    input  valid, adjusted_slope, run_end, status,
    output ready
  );
endinterface

`default_nettype wire

@@ hdl/hpdc_bound.sv @@
// one slope bound +-(3*mu*value/interval), truncated and saturated
// bit-serial shift-add multiply then restoring divide; uses hpdc_pkg
`default_nettype none

module hpdc_bound #(
  parameter int DATA_WIDTH = hpdc_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = hpdc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [hpdc_pkg::A_W-1:0] a_i,
  input  wire logic [DATA_WIDTH-1:0]    value_i,
  input  wire logic [DATA_WIDTH-1:0]    k_hi_i,
  input  wire logic [DATA_WIDTH-1:0]    k_lo_i,
  input  wire logic                     negate_i,
  output logic                          done_o,
  output logic [DATA_WIDTH-1:0]         result_o
);

  localparam int AW   = hpdc_pkg::A_W;
  localparam int NSH  = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
  localparam int DSH  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int PW   = DATA_WIDTH + AW;
  localparam int NW   = PW + NSH;
  localparam int DWD  = DATA_WIDTH + DSH;
  localparam int QW   = DATA_WIDTH + 1;
  localparam int HW   = NW - QW;
  localparam int CW   = (HW > DWD) ? HW : DWD;
  localparam int CMAX = (AW > QW) ? AW : QW;
  localparam int CNT_W = $clog2(CMAX);

  localparam logic [QW-1:0] SIGN_Q = {{(QW-1){1'b0}}, 1'b1} << (DATA_WIDTH - 1);
  localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  hpdc_pkg::bnd_state_e state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [DATA_WIDTH-1:0]  mv_q, mv_d;
  logic [DWD-1:0]         d_q, d_d;
  logic                   neg_q, neg_d;
  logic [AW-1:0]          a_sh_q, a_sh_d;
  logic [PW-1:0]          p_q, p_d;
  logic [DWD-1:0]         r_q, r_d;
  logic [QW-1:0]          lo_q, lo_d;
  logic                   ovf_q, ovf_d;
  logic                   zero_q, zero_d;
  logic [DATA_WIDTH-1:0]  result_q, result_d;
  logic                   done_q, done_d;

  logic [DATA_WIDTH:0]    kdiff;
  logic [DATA_WIDTH-1:0]  di;
  logic [NW-1:0]          num;
  logic [HW-1:0]          num_hi;
  logic [DWD:0]           rs;
  logic                   ge;
  logic [QW-1:0]          mag;
  logic [QW-1:0]          mag_neg;

  assign kdiff   = {k_hi_i[DATA_WIDTH-1], k_hi_i} - {k_lo_i[DATA_WIDTH-1], k_lo_i};
  assign di      = kdiff[DATA_WIDTH] ? DATA_WIDTH'(-kdiff) : kdiff[DATA_WIDTH-1:0];
  assign num     = NW'(p_q) << NSH;
  assign num_hi  = num[NW-1:QW];
  assign rs      = {r_q, lo_q[QW-1]};
  assign ge      = rs >= {1'b0, d_q};
  assign mag     = (ovf_q || lo_q > SIGN_Q) ? SIGN_Q : lo_q;
  assign mag_neg = ~mag + {{(QW-1){1'b0}}, 1'b1};

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    mv_d     = mv_q;
    d_d      = d_q;
    neg_d    = neg_q;
    a_sh_d   = a_sh_q;
    p_d      = p_q;
    r_d      = r_q;
    lo_d     = lo_q;
    ovf_d    = ovf_q;
    zero_d   = zero_q;
    result_d = result_q;
    done_d   = 1'b0;
    unique case (state_q)
      hpdc_pkg::BS_IDLE: begin
        if (start_i) begin
          mv_d    = value_i[DATA_WIDTH-1] ? DATA_WIDTH'(-value_i) : value_i;
          d_d     = DWD'(di) << DSH;
          neg_d   = value_i[DATA_WIDTH-1] ^ kdiff[DATA_WIDTH] ^ negate_i;
          a_sh_d  = a_i;
          p_d     = '0;
          cnt_d   = CNT_W'(AW - 1);
          state_d = hpdc_pkg::BS_MUL;
        end
      end
      hpdc_pkg::BS_MUL: begin
        // msb first: p = 2p + bit*mv
        p_d    = (p_q << 1) + (a_sh_q[AW-1] ? PW'(mv_q) : '0);
        a_sh_d = a_sh_q << 1;
        if (cnt_q == '0) begin
          state_d = hpdc_pkg::BS_CHK;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      hpdc_pkg::BS_CHK: begin
        zero_d = 1'b0;
        ovf_d  = 1'b0;
        if (p_q == '0) begin
          // zero mu or zero value gives zero, even over a zero interval
          zero_d  = 1'b1;
          state_d = hpdc_pkg::BS_SAT;
        end else if (CW'(num_hi) >= CW'(d_q)) begin
          // quotient needs more than QW bits, also catches a zero interval
          ovf_d   = 1'b1;
          state_d = hpdc_pkg::BS_SAT;
        end else begin
          r_d     = DWD'(num_hi);
          lo_d    = num[QW-1:0];
          cnt_d   = CNT_W'(QW - 1);
          state_d = hpdc_pkg::BS_DIV;
        end
      end
      hpdc_pkg::BS_DIV: begin
        // dividend bits leave at the top of lo_q, quotient bits enter at the bottom
        r_d  = ge ? DWD'(rs - {1'b0, d_q}) : DWD'(rs);
        lo_d = {lo_q[QW-2:0], ge};
        if (cnt_q == '0) begin
          state_d = hpdc_pkg::BS_SAT;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      hpdc_pkg::BS_SAT: begin
        if (zero_q) begin
          result_d = '0;
        end else if (neg_q) begin
          result_d = mag_neg[DATA_WIDTH-1:0];
        end else if (ovf_q || lo_q >= SIGN_Q) begin
          result_d = MAX_POS;
        end else begin
          result_d = lo_q[DATA_WIDTH-1:0];
        end
        done_d  = 1'b1;
        state_d = hpdc_pkg::BS_IDLE;
      end
      default: begin
        state_d = hpdc_pkg::BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hpdc_pkg::BS_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    mv_q     <= mv_d;
    d_q      <= d_d;
    neg_q    <= neg_d;
    a_sh_q   <= a_sh_d;
    p_q      <= p_d;
    r_q      <= r_d;
    lo_q     <= lo_d;
    ovf_q    <= ovf_d;
    zero_q   <= zero_d;
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

@@ hdl/hermite_positivity_derivative_clamp.sv @@
// top level of the positivity-preserving hermite derivative clamp
// uses hpdc_pkg, the channel interfaces in hpdc_if.sv and hpdc_bound
`default_nettype none

// Clamps the derivative of each point of a run of cubic hermite data so that
// the bezier control values stay positive: a slope may not exceed
// 3*mu*value/(left interval) nor fall below -3*mu*value/(right interval).
// The first point of a run is held to the lower limit only, the last to the
// upper limit only, and an endpoint that is not clamped gives zero while mu
// is zero. Results come one point late: a point's word leaves when the next
// point arrives, and the marked last point releases two words. A run of a
// single point gives one word with slope 0, run_end 1 and status 1. Values,
// slopes and knots are signed q(FRAC_BITS); a zero interval or a bound out of
// range saturates. mu sits in register 0 (unsigned q0.16) on the register
// port; write it only between runs or while the block is idle. Timing: one
// point at a time. Each bound is worked by a single bit-serial unit, an
// 18-step shift-add multiply followed by a DATA_WIDTH+1 step restoring
// divide that is skipped for a zero product or an overflowing quotient. An
// interior point needs up to two bounds; a first point takes one bound, a
// last point one more, and the first point of a run is just held on arrival,
// with no bound, while the block stays ready. A finished word waits in the
// output register while the next point is taken.

module hermite_positivity_derivative_clamp #(
  parameter int DATA_WIDTH = hpdc_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = hpdc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // point words in, result words out
  hpdc_in_if.sink                            in_i,
  hpdc_out_if.source                         out_o,
  // register port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [hpdc_pkg::APB_AW-1:0]   paddr,
  input  wire logic [hpdc_pkg::APB_DW-1:0]   pwdata,
  output logic      [hpdc_pkg::APB_DW-1:0]   prdata,
  output logic                               pready
);

  localparam int MU_W = hpdc_pkg::MU_W;
  localparam int A_W  = hpdc_pkg::A_W;

  // ---------------------------------------------------------------------------
  // mu register
  // ---------------------------------------------------------------------------
  logic [MU_W-1:0] mu_q, mu_d;
  logic            reg_sel_mu;
  logic [A_W-1:0]  a3mu;

  assign pready     = 1'b1;
  assign reg_sel_mu = (paddr[hpdc_pkg::APB_AW-1] == hpdc_pkg::REG_MU_FACTOR);
  assign prdata     = reg_sel_mu ? hpdc_pkg::APB_DW'(mu_q) : '0;

  always_comb begin
    mu_d = mu_q;
    if (psel && penable && pwrite && pready && reg_sel_mu) begin
      mu_d = pwdata[MU_W-1:0];
    end
  end

  // 3*mu as shift and add
  assign a3mu = {1'b0, mu_q, 1'b0} + {2'b00, mu_q};

  // ---------------------------------------------------------------------------
  // run state and sequencer
  // ---------------------------------------------------------------------------
  hpdc_pkg::top_state_e state_q, state_d;
  hpdc_pkg::phase_e     phase_q, phase_d;

  // point waiting for its successor
  logic [DATA_WIDTH-1:0] held_value_q, held_value_d;
  logic [DATA_WIDTH-1:0] held_slope_q, held_slope_d;
  logic [DATA_WIDTH-1:0] held_knot_q,  held_knot_d;
  logic [DATA_WIDTH-1:0] kbh_q,        kbh_d;
  logic                  have_held_q,  have_held_d;
  logic                  held_first_q, held_first_d;

  // point just taken
  logic [DATA_WIDTH-1:0] new_value_q, new_value_d;
  logic [DATA_WIDTH-1:0] new_slope_q, new_slope_d;
  logic [DATA_WIDTH-1:0] new_knot_q,  new_knot_d;
  logic                  new_fin_q,   new_fin_d;

  // slope of the word being built
  logic [DATA_WIDTH-1:0] res_q, res_d;

  // output register
  logic                  out_valid_q;
  logic [DATA_WIDTH-1:0] out_slope_q;
  logic                  out_end_q;
  logic                  out_status_q;
  logic                  out_load;

  // bound unit hookup
  logic                  bnd_start;
  logic [DATA_WIDTH-1:0] bnd_value;
  logic [DATA_WIDTH-1:0] bnd_khi;
  logic [DATA_WIDTH-1:0] bnd_klo;
  logic                  bnd_neg;
  logic                  bnd_done;
  logic [DATA_WIDTH-1:0] bnd_res;

  logic                  in_acc;

  assign in_acc = in_i.valid && in_i.ready;

  // operands for the bound named by the phase
  always_comb begin
    bnd_value = held_value_q;
    bnd_khi   = held_knot_q;
    bnd_klo   = kbh_q;
    bnd_neg   = 1'b0;
    unique case (phase_q)
      hpdc_pkg::PH_A_UP: begin
        // upper limit of the held point over its left interval
        bnd_value = held_value_q;
        bnd_khi   = held_knot_q;
        bnd_klo   = kbh_q;
        bnd_neg   = 1'b0;
      end
      hpdc_pkg::PH_A_LO: begin
        // lower limit of the held point over its right interval
        bnd_value = held_value_q;
        bnd_khi   = new_knot_q;
        bnd_klo   = held_knot_q;
        bnd_neg   = 1'b1;
      end
      hpdc_pkg::PH_B_UP: begin
        // upper limit of the last point
        bnd_value = new_value_q;
        bnd_khi   = new_knot_q;
        bnd_klo   = held_knot_q;
        bnd_neg   = 1'b0;
      end
      hpdc_pkg::PH_SINGLE: begin
        bnd_value = '0;
        bnd_khi   = '0;
        bnd_klo   = '0;
        bnd_neg   = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    held_value_d = held_value_q;
    held_slope_d = held_slope_q;
    held_knot_d  = held_knot_q;
    kbh_d        = kbh_q;
    have_held_d  = have_held_q;
    held_first_d = held_first_q;
    new_value_d  = new_value_q;
    new_slope_d  = new_slope_q;
    new_knot_d   = new_knot_q;
    new_fin_d    = new_fin_q;
    res_d        = res_q;
    out_load     = 1'b0;
    bnd_start    = 1'b0;
    in_i.ready   = 1'b0;
    unique case (state_q)
      hpdc_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_acc) begin
          if (!have_held_q) begin
            if (in_i.final_point) begin
              // run of one point: error word
              res_d        = '0;
              phase_d      = hpdc_pkg::PH_SINGLE;
              held_first_d = 1'b1;
              state_d      = hpdc_pkg::ST_EMIT;
            end else begin
              // first point of a run: just hold it
              held_value_d = in_i.point_value;
              held_slope_d = in_i.point_slope;
              held_knot_d  = in_i.knot;
              have_held_d  = 1'b1;
              held_first_d = 1'b1;
            end
          end else begin
            new_value_d = in_i.point_value;
            new_slope_d = in_i.point_slope;
            new_knot_d  = in_i.knot;
            new_fin_d   = in_i.final_point;
            // a first point skips the upper limit
            phase_d     = held_first_q ? hpdc_pkg::PH_A_LO : hpdc_pkg::PH_A_UP;
            state_d     = hpdc_pkg::ST_LAUNCH;
          end
        end
      end
      hpdc_pkg::ST_LAUNCH: begin
        bnd_start = 1'b1;
        state_d   = hpdc_pkg::ST_BOUND;
      end
      hpdc_pkg::ST_BOUND: begin
        if (bnd_done) begin
          unique case (phase_q)
            hpdc_pkg::PH_A_UP: begin
              if ($signed(bnd_res) < $signed(held_slope_q)) begin
                res_d   = bnd_res;
                state_d = hpdc_pkg::ST_EMIT;
              end else begin
                phase_d = hpdc_pkg::PH_A_LO;
                state_d = hpdc_pkg::ST_LAUNCH;
              end
            end
            hpdc_pkg::PH_A_LO: begin
              if ($signed(held_slope_q) < $signed(bnd_res)) begin
                res_d = bnd_res;
              end else if (held_first_q && mu_q == '0) begin
                // unclamped endpoint with zero mu
                res_d = '0;
              end else begin
                res_d = held_slope_q;
              end
              state_d = hpdc_pkg::ST_EMIT;
            end
            hpdc_pkg::PH_B_UP: begin
              if ($signed(bnd_res) < $signed(new_slope_q)) begin
                res_d = bnd_res;
              end else if (mu_q == '0) begin
                res_d = '0;
              end else begin
                res_d = new_slope_q;
              end
              state_d = hpdc_pkg::ST_EMIT;
            end
            hpdc_pkg::PH_SINGLE: begin
              state_d = hpdc_pkg::ST_EMIT;
            end
          endcase
        end
      end
      hpdc_pkg::ST_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          unique case (phase_q)
            hpdc_pkg::PH_A_UP, hpdc_pkg::PH_A_LO: begin
              if (new_fin_q) begin
                // last point still owes its own word
                phase_d = hpdc_pkg::PH_B_UP;
                state_d = hpdc_pkg::ST_LAUNCH;
              end else begin
                kbh_d        = held_knot_q;
                held_value_d = new_value_q;
                held_slope_d = new_slope_q;
                held_knot_d  = new_knot_q;
                held_first_d = 1'b0;
                state_d      = hpdc_pkg::ST_IDLE;
              end
            end
            hpdc_pkg::PH_B_UP: begin
              have_held_d  = 1'b0;
              held_first_d = 1'b1;
              state_d      = hpdc_pkg::ST_IDLE;
            end
            hpdc_pkg::PH_SINGLE: begin
              state_d = hpdc_pkg::ST_IDLE;
            end
          endcase
        end
      end
    endcase
  end

  hpdc_bound #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_bound (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (bnd_start),
    .a_i      (a3mu),
    .value_i  (bnd_value),
    .k_hi_i   (bnd_khi),
    .k_lo_i   (bnd_klo),
    .negate_i (bnd_neg),
    .done_o   (bnd_done),
    .result_o (bnd_res)
  );

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_q         <= '0;
      state_q      <= hpdc_pkg::ST_IDLE;
      phase_q      <= hpdc_pkg::PH_A_UP;
      have_held_q  <= 1'b0;
      held_first_q <= 1'b1;
      held_value_q <= '0;
      held_slope_q <= '0;
      held_knot_q  <= '0;
      kbh_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      mu_q         <= mu_d;
      state_q      <= state_d;
      phase_q      <= phase_d;
      have_held_q  <= have_held_d;
      held_first_q <= held_first_d;
      held_value_q <= held_value_d;
      held_slope_q <= held_slope_d;
      held_knot_q  <= held_knot_d;
      kbh_q        <= kbh_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    new_value_q <= new_value_d;
    new_slope_q <= new_slope_d;
    new_knot_q  <= new_knot_d;
    new_fin_q   <= new_fin_d;
    res_q       <= res_d;
    if (out_load) begin
      out_slope_q  <= res_q;
      out_end_q    <= (phase_q == hpdc_pkg::PH_B_UP) || (phase_q == hpdc_pkg::PH_SINGLE);
      out_status_q <= (phase_q == hpdc_pkg::PH_SINGLE) ? hpdc_pkg::STATUS_SHORT_RUN
                                                         : hpdc_pkg::STATUS_OK;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.adjusted_slope = out_slope_q;
  assign out_o.run_end        = out_end_q;
  assign out_o.status         = out_status_q;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
`ifndef SYNTH
  // never overwrite a word that has not been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_o.ready))
    else $error("output word overwritten");

  // the bound unit only answers while the sequencer waits for it
  a_done_in_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bnd_done |-> (state_q == hpdc_pkg::ST_BOUND))
    else $error("bound finished outside of bound state");

  // an error word always closes its run
  a_status_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == hpdc_pkg::STATUS_SHORT_RUN) |-> out_end_q)
    else $error("short-run status without run_end");

  // with nothing held the next point is the first of a run
  a_empty_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !have_held_q |-> held_first_q)
    else $error("empty hold not marked as run start");
`endif

endmodule

`default_nettype wire
